[hdl/cal_pkg.sv]
package cal_pkg;

    localparam logic [13:0] FloorYear = 14'd1753;
    localparam logic [3:0]  MonthJan  = 4'd1;
    localparam logic [3:0]  MonthFeb  = 4'd2;
    localparam logic [3:0]  MonthMar  = 4'd3;
    localparam logic [3:0]  MonthDec  = 4'd12;
    localparam logic [4:0]  DayFirst  = 5'd1;
    localparam logic [4:0]  DayLast   = 5'd31;

    // inverse of 25 modulo 2^14 and the largest image of a multiple of 25
    localparam logic [13:0] Inv25     = 14'd7209;
    localparam logic [13:0] Div25Max  = 14'd655;

    typedef enum logic [1:0] {
        OP_INC  = 2'd0,
        OP_DEC  = 2'd1,
        OP_LOAD = 2'd2,
        OP_NOP  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FLOOR    = 2'd1,
        ST_BAD_LOAD = 2'd2,
        ST_CEILING  = 2'd3
    } status_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    typedef struct packed {
        opcode_t opcode;
        date_t   load;
        logic    load_leap;
    } cmd_t;

    function automatic logic is_leap(input logic [13:0] y);
        logic [13:0] img;
        logic        div25;
        img   = y * Inv25;
        div25 = (img <= Div25Max);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month) inside
            MonthFeb: begin
                len = leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

    function automatic logic [2:0] sak_offset(input logic [3:0] month);
        logic [2:0] off;
        case (month)
            4'd1:    off = 3'd0;
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

endpackage

[hdl/cal_date_step.sv]
module cal_date_step #(
    parameter int MAX_YEAR = 9999
) (
    input  cal_pkg::date_t   cur,
    input  cal_pkg::cmd_t    cmd,
    output cal_pkg::date_t   nxt,
    output cal_pkg::status_t status
);
    import cal_pkg::*;

    localparam logic [13:0] MaxYear = 14'(MAX_YEAR);

    logic       leap_cur;
    logic [4:0] len_cur;
    logic [4:0] len_prev;
    logic       load_ok;

    assign leap_cur = is_leap(cur.year);
    assign len_cur  = month_len(cur.month, leap_cur);
    assign len_prev = month_len(cur.month - 4'd1, leap_cur);

    assign load_ok = (cmd.load.year >= FloorYear) && (cmd.load.year <= MaxYear)
                  && (cmd.load.month >= MonthJan) && (cmd.load.month <= MonthDec)
                  && (cmd.load.day >= DayFirst)
                  && (cmd.load.day <= month_len(cmd.load.month, cmd.load_leap));

    always_comb begin
        nxt    = cur;
        status = ST_OK;
        case (cmd.opcode)
            OP_INC: begin
                if (cur.year >= MaxYear && cur.month == MonthDec && cur.day == DayLast) begin
                    status = ST_CEILING;
                end else if (cur.day < len_cur) begin
                    nxt.day = cur.day + 5'd1;
                end else if (cur.month < MonthDec) begin
                    nxt.month = cur.month + 4'd1;
                    nxt.day   = DayFirst;
                end else begin
                    nxt.year  = cur.year + 14'd1;
                    nxt.month = MonthJan;
                    nxt.day   = DayFirst;
                end
            end
            OP_DEC: begin
                if (cur.year <= FloorYear && cur.month == MonthJan && cur.day == DayFirst) begin
                    status = ST_FLOOR;
                end else if (cur.day > DayFirst) begin
                    nxt.day = cur.day - 5'd1;
                end else if (cur.month > MonthJan) begin
                    nxt.month = cur.month - 4'd1;
                    nxt.day   = len_prev;
                end else begin
                    nxt.year  = cur.year - 14'd1;
                    nxt.month = MonthDec;
                    nxt.day   = DayLast;
                end
            end
            OP_LOAD: begin
                if (load_ok) begin
                    nxt = cmd.load;
                end else begin
                    status = ST_BAD_LOAD;
                end
            end
            default: begin
                nxt    = cur;
                status = ST_OK;
            end
        endcase
    end

endmodule

[hdl/cal_weekday.sv]
module cal_weekday (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  cal_pkg::date_t   in_date,
    input  cal_pkg::status_t in_status,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,  // date_year, date_month, date_day, weekday
    output logic [1:0]       m_tuser   // status
);
    import cal_pkg::*;

    localparam logic [12:0] Recip100 = 13'd5243;
    localparam logic [13:0] Recip7   = 14'd9362;

    // first stage: year split for sakamoto terms
    logic [13:0] yy;
    logic [26:0] prod100;

    logic        vb_reg, vb_next;
    logic [13:0] yy_reg;
    logic [7:0]  q100_reg;
    logic [5:0]  td_reg;
    date_t       date_b_reg;
    status_t     status_b_reg;

    // second stage: sum modulo 7
    logic [14:0] sum;
    logic [28:0] prod7;
    logic [12:0] q7;
    logic [14:0] rem;
    logic [2:0]  wday;

    logic        vc_reg, vc_next;
    logic [31:0] data_reg;
    status_t     status_c_reg;
    logic        rdy_c;

    assign rdy_c    = !vc_reg || m_tready;
    assign in_ready = !vb_reg || rdy_c;

    assign yy      = (in_date.month < MonthMar) ? in_date.year - 14'd1 : in_date.year;
    assign prod100 = 27'(yy) * 27'(Recip100);

    assign sum   = 15'(yy_reg) + 15'(yy_reg[13:2]) - 15'(q100_reg) + 15'(q100_reg[7:2])
                 + 15'(td_reg);
    assign prod7 = 29'(sum) * 29'(Recip7);
    assign q7    = prod7[28:16];
    assign rem   = sum - (15'({q7, 3'b000}) - 15'(q7));
    assign wday  = (rem[3:0] >= 4'd7) ? 3'(rem[3:0] - 4'd7) : rem[2:0];

    assign vb_next = in_ready ? in_valid : vb_reg;
    assign vc_next = rdy_c ? vb_reg : vc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            vb_reg <= vb_next;
            vc_reg <= vc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            yy_reg       <= yy;
            q100_reg     <= prod100[26:19];
            td_reg       <= 6'(sak_offset(in_date.month)) + 6'(in_date.day);
            date_b_reg   <= in_date;
            status_b_reg <= in_status;
        end
        if (rdy_c && vb_reg) begin
            data_reg     <= {6'b000000, wday, date_b_reg.day, date_b_reg.month,
                             date_b_reg.year};
            status_c_reg <= status_b_reg;
        end
    end

    assign m_tvalid = vc_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = status_c_reg;

endmodule

[hdl/calendar_date_counter.sv]
// throughput: one command per cycle unless m_tready stalls the output, limited
// by the single-cycle date update loop
// stages: command register, date state register, sakamoto split, weekday result
// reset: synchronous active-low aresetn sets the date to 1753-01-01 and empties
// every stage; no result is pending after reset
module calendar_date_counter #(
    parameter int MAX_YEAR = 9999
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // load_year, load_month, load_day
    input  logic [1:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // date_year, date_month, date_day, weekday
    output logic [1:0]  m_tuser    // status
);
    import cal_pkg::*;

    localparam logic [13:0] MaxYear = 14'(MAX_YEAR);

    logic    v0_reg, v0_next;
    cmd_t    cmd_reg;
    cmd_t    cmd_in;

    logic    v1_reg, v1_next;
    date_t   date_reg, date_next;
    status_t status_reg;
    status_t status_next;

    logic    rdy1;
    logic    wd_ready;
    logic    step;

    assign cmd_in.opcode     = opcode_t'(s_tuser);
    assign cmd_in.load.year  = s_tdata[13:0];
    assign cmd_in.load.month = s_tdata[17:14];
    assign cmd_in.load.day   = s_tdata[22:18];
    assign cmd_in.load_leap  = is_leap(s_tdata[13:0]);

    assign rdy1     = !v1_reg || wd_ready;
    assign s_tready = !v0_reg || rdy1;
    assign step     = v0_reg && rdy1;

    assign v0_next = s_tready ? s_tvalid : v0_reg;
    assign v1_next = rdy1 ? v0_reg : v1_reg;

    cal_date_step #(
        .MAX_YEAR (MAX_YEAR)
    ) u_step (
        .cur    (date_reg),
        .cmd    (cmd_reg),
        .nxt    (date_next),
        .status (status_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg         <= 1'b0;
            v1_reg         <= 1'b0;
            date_reg.year  <= FloorYear;
            date_reg.month <= MonthJan;
            date_reg.day   <= DayFirst;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            if (step) begin
                date_reg <= date_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= cmd_in;
        end
        if (step) begin
            status_reg <= status_next;
        end
    end

    cal_weekday u_weekday (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1_reg),
        .in_ready  (wd_ready),
        .in_date   (date_reg),
        .in_status (status_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    a_date_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (date_reg.month >= MonthJan) && (date_reg.month <= MonthDec)
        && (date_reg.day >= DayFirst) && (date_reg.year >= FloorYear)
        && (date_reg.year <= MaxYear))
        else $error("date state out of range");

    a_date_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(date_reg))
        else $error("date changed without a command");

    a_floor_refusal: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && status_reg == ST_FLOOR) |-> (date_reg.year == FloorYear
        && date_reg.month == MonthJan && date_reg.day == DayFirst))
        else $error("floor refusal away from floor date");

    a_ceiling_refusal: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && status_reg == ST_CEILING) |-> (date_reg.year == MaxYear
        && date_reg.month == MonthDec && date_reg.day == DayLast))
        else $error("ceiling refusal away from ceiling date");

    a_weekday_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[25:23] <= 3'd6))
        else $error("weekday out of range");

endmodule

[tb/calendar_date_counter_test.sv]
module calendar_date_counter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cal_pkg::*;

    localparam int MaxYear     = 9999;
    localparam int MinYear     = 1753;
    localparam int RandomCmds  = 1950;
    localparam int NumDirected = 25;
    localparam int DrainCycles = 12;
    localparam int CycleLimit  = 400000;

    localparam int MonthShift [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        status_t     status;
    } cal_result_t;

    typedef struct packed {
        opcode_t     op;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        known;
        cal_result_t result;
    } cal_vector_t;

    localparam cal_vector_t DirectedCmds [NumDirected] = '{
        '{OP_DEC,  14'd0,     4'd0,  5'd0,  1'b1, '{14'd1753, 4'd1,  5'd1,  3'd1, ST_FLOOR}},
        '{OP_NOP,  14'd16383, 4'd15, 5'd31, 1'b1, '{14'd1753, 4'd1,  5'd1,  3'd1, ST_OK}},
        '{OP_INC,  14'd16383, 4'd15, 5'd31, 1'b1, '{14'd1753, 4'd1,  5'd2,  3'd2, ST_OK}},
        '{OP_DEC,  14'd0,     4'd0,  5'd0,  1'b1, '{14'd1753, 4'd1,  5'd1,  3'd1, ST_OK}},
        '{OP_LOAD, 14'd0,     4'd0,  5'd0,  1'b1, '{14'd1753, 4'd1,  5'd1,  3'd1, ST_BAD_LOAD}},
        '{OP_LOAD, 14'd1752,  4'd12, 5'd31, 1'b1, '{14'd1753, 4'd1,  5'd1,  3'd1, ST_BAD_LOAD}},
        '{OP_LOAD, 14'd10000, 4'd1,  5'd1,  1'b1, '{14'd1753, 4'd1,  5'd1,  3'd1, ST_BAD_LOAD}},
        '{OP_LOAD, 14'd16383, 4'd15, 5'd31, 1'b1, '{14'd1753, 4'd1,  5'd1,  3'd1, ST_BAD_LOAD}},
        '{OP_LOAD, 14'd2000,  4'd0,  5'd5,  1'b1, '{14'd1753, 4'd1,  5'd1,  3'd1, ST_BAD_LOAD}},
        '{OP_LOAD, 14'd2000,  4'd13, 5'd5,  1'b1, '{14'd1753, 4'd1,  5'd1,  3'd1, ST_BAD_LOAD}},
        '{OP_LOAD, 14'd2000,  4'd2,  5'd0,  1'b1, '{14'd1753, 4'd1,  5'd1,  3'd1, ST_BAD_LOAD}},
        '{OP_LOAD, 14'd1900,  4'd2,  5'd29, 1'b1, '{14'd1753, 4'd1,  5'd1,  3'd1, ST_BAD_LOAD}},
        '{OP_LOAD, 14'd2001,  4'd4,  5'd31, 1'b1, '{14'd1753, 4'd1,  5'd1,  3'd1, ST_BAD_LOAD}},
        '{OP_LOAD, 14'd2000,  4'd2,  5'd29, 1'b0, '0},
        '{OP_INC,  14'd0,     4'd0,  5'd0,  1'b0, '0},
        '{OP_DEC,  14'd0,     4'd0,  5'd0,  1'b0, '0},
        '{OP_LOAD, 14'd1900,  4'd2,  5'd28, 1'b0, '0},
        '{OP_INC,  14'd0,     4'd0,  5'd0,  1'b0, '0},
        '{OP_LOAD, 14'd1999,  4'd12, 5'd31, 1'b0, '0},
        '{OP_INC,  14'd0,     4'd0,  5'd0,  1'b0, '0},
        '{OP_LOAD, 14'd9999,  4'd12, 5'd31, 1'b1, '{14'd9999, 4'd12, 5'd31, 3'd5, ST_OK}},
        '{OP_INC,  14'd0,     4'd0,  5'd0,  1'b1, '{14'd9999, 4'd12, 5'd31, 3'd5, ST_CEILING}},
        '{OP_LOAD, 14'd1753,  4'd1,  5'd2,  1'b0, '0},
        '{OP_DEC,  14'd0,     4'd0,  5'd0,  1'b0, '0},
        '{OP_DEC,  14'd0,     4'd0,  5'd0,  1'b1, '{14'd1753, 4'd1,  5'd1,  3'd1, ST_FLOOR}}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;    // load_year, load_month, load_day
    logic [1:0]  s_tuser  = '0;    // opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // date_year, date_month, date_day, weekday
    logic [1:0]  m_tuser;          // status

    cal_result_t expected_dates [$];
    cal_result_t want;
    int          cal_year;
    int          cal_month;
    int          cal_day;
    int          errors      = 0;
    int          cmds_sent   = 0;
    int          words_seen  = 0;
    int          cycle_count = 0;
    int          status_seen [4] = '{0, 0, 0, 0};
    bit          quiet       = 1'b0;

    calendar_date_counter #(
        .MAX_YEAR(MaxYear)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic bit leap_year(input int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int days_in_month(input int y, input int m);
        if (m == 2) begin
            return leap_year(y) ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic int weekday_of(input int y, input int m, input int d);
        int yy;
        yy = (m < 3) ? y - 1 : y;
        return (yy + yy / 4 - yy / 100 + yy / 400 + MonthShift[m - 1] + d) % 7;
    endfunction

    // applies one command to the tracked date and returns the word it should produce
    function automatic cal_result_t step_calendar(input opcode_t op, input int ly,
                                                  input int lm, input int ld);
        cal_result_t r;
        status_t     st;
        st = ST_OK;
        case (op)
            OP_INC: begin
                if (cal_year >= MaxYear && cal_month == 12 && cal_day == 31) begin
                    st = ST_CEILING;
                end else if (cal_day < days_in_month(cal_year, cal_month)) begin
                    cal_day++;
                end else if (cal_month < 12) begin
                    cal_month++;
                    cal_day = 1;
                end else begin
                    cal_year++;
                    cal_month = 1;
                    cal_day = 1;
                end
            end
            OP_DEC: begin
                if (cal_year <= MinYear && cal_month == 1 && cal_day == 1) begin
                    st = ST_FLOOR;
                end else if (cal_day > 1) begin
                    cal_day--;
                end else if (cal_month > 1) begin
                    cal_month--;
                    cal_day = days_in_month(cal_year, cal_month);
                end else begin
                    cal_year--;
                    cal_month = 12;
                    cal_day = 31;
                end
            end
            OP_LOAD: begin
                if (ly >= MinYear && ly <= MaxYear && lm >= 1 && lm <= 12 && ld >= 1 &&
                    ld <= days_in_month(ly, lm)) begin
                    cal_year = ly;
                    cal_month = lm;
                    cal_day = ld;
                end else begin
                    st = ST_BAD_LOAD;
                end
            end
            default: begin
            end
        endcase
        r.year    = 14'(cal_year);
        r.month   = 4'(cal_month);
        r.day     = 5'(cal_day);
        r.weekday = 3'(weekday_of(cal_year, cal_month, cal_day));
        r.status  = st;
        return r;
    endfunction

    task automatic send_command(input opcode_t op, input int ly, input int lm, input int ld,
                                input bit known = 1'b0, input cal_result_t typed = '0);
        cal_result_t predicted;
        while (!quiet && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, 5'(ld), 4'(lm), 14'(ly)};
        do @(posedge aclk); while (!s_tready);
        predicted = step_calendar(op, ly, lm, ld);
        expected_dates.push_back(known ? typed : predicted);
        cmds_sent++;
    endtask

    // run of day steps, mostly in one direction, with ignored load fields
    task automatic step_run(input int count);
        opcode_t dir;
        opcode_t op;
        dir = $urandom_range(1) ? OP_INC : OP_DEC;
        repeat (count) begin
            op = dir;
            if ($urandom_range(9) == 0) begin
                op = (dir == OP_INC) ? OP_DEC : OP_INC;
            end
            send_command(op, $urandom_range(16383), $urandom_range(15), $urandom_range(31));
        end
    endtask

    // dates near month, year, floor and ceiling edges, now and then one day too far
    task automatic pick_edge_date(output int y, output int m, output int d);
        int len;
        case ($urandom_range(5))
            0: y = MinYear;
            1: y = MaxYear;
            2: y = 100 * $urandom_range(99, 18);
            3: y = 400 * $urandom_range(24, 5);
            default: y = $urandom_range(MaxYear, MinYear);
        endcase
        m = $urandom_range(12, 1);
        if ($urandom_range(3) == 0) begin
            m = 2;
        end
        if (y == MinYear && $urandom_range(1)) begin
            m = 1;
        end
        if (y == MaxYear && $urandom_range(1)) begin
            m = 12;
        end
        len = days_in_month(y, m);
        case ($urandom_range(3))
            0: d = len - $urandom_range(2);
            1: d = $urandom_range(3, 1);
            2: d = len;
            default: d = len + $urandom_range(1);
        endcase
    endtask

    function automatic void check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 21);
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (expected_dates.size() == 0) begin
                $error("result word with nothing expected: tdata %h tuser %0d", m_tdata, m_tuser);
                errors++;
            end else begin
                want = expected_dates.pop_front();
                status_seen[want.status]++;
                check_field("date_year", want.year, m_tdata[13:0]);
                check_field("date_month", want.month, m_tdata[17:14]);
                check_field("date_day", want.day, m_tdata[22:18]);
                check_field("weekday", want.weekday, m_tdata[25:23]);
                check_field("status", want.status, m_tuser);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_dates.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int y;
        int m;
        int d;
        int pick;
        bit drained;
        drained = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        cal_year  = MinYear;
        cal_month = 1;
        cal_day   = 1;

        for (int i = 0; i < NumDirected; i++) begin
            send_command(DirectedCmds[i].op, DirectedCmds[i].year, DirectedCmds[i].month,
                         DirectedCmds[i].day, DirectedCmds[i].known, DirectedCmds[i].result);
        end

        while (cmds_sent < NumDirected + RandomCmds) begin
            quiet = (cmds_sent >= 700 && cmds_sent < 1000);
            if (!drained && cmds_sent >= 1200) begin
                // hold off until the pipeline is empty
                s_tvalid <= 1'b0;
                while (expected_dates.size() != 0) @(posedge aclk);
                drained = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 40) begin
                pick_edge_date(y, m, d);
                send_command(OP_LOAD, y, m, d);
                step_run($urandom_range(8, 1));
            end else if (pick < 65) begin
                step_run($urandom_range(40, 1));
            end else if (pick < 85) begin
                send_command(OP_LOAD, $urandom_range(16383), $urandom_range(15),
                             $urandom_range(31));
            end else if (pick < 90) begin
                send_command(OP_NOP, $urandom_range(16383), $urandom_range(15),
                             $urandom_range(31));
            end else begin
                y = $urandom_range(MaxYear, MinYear);
                m = $urandom_range(12, 1);
                d = $urandom_range(days_in_month(y, m), 1);
                send_command(OP_LOAD, y, m, d);
            end
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        while (expected_dates.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("%0d commands driven, %0d result words checked", cmds_sent, words_seen);
        $display("floor refusals %0d, ceiling refusals %0d, rejected loads %0d, errors %0d",
                 status_seen[ST_FLOOR], status_seen[ST_CEILING], status_seen[ST_BAD_LOAD],
                 errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
